/* rtl/core/shj_pkg.sv */
// Package for the signature histogram Jaccard block.
// Holds opcode and status codes and the signature width; no dependencies.
package shj_pkg;
  localparam int SIG_W = 21;
  localparam int MAX_ELEMENT_TYPES = 8;
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD_A = 2'd1;
  localparam logic [1:0] OP_ADD_B = 2'd2;
  localparam logic [1:0] OP_CMP   = 2'd3;
  localparam logic [1:0] ST_NEW   = 2'd0;
  localparam logic [1:0] ST_OLD   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;
  typedef logic [SIG_W-1:0] sig_t;
endpackage

/* rtl/core/signature_histogram_jaccard.sv */
// Top level: two signature histograms with weighted Jaccard compare.
// Depends on shj_pkg. Tables are single-port memories walked by a sequencer.
// Add: one table read per slot, then a write. Compare: walks of both tables
// (min and max counts summed) followed by a shift-subtract divide.
// One word in flight; in_stall high while busy or result held.
// Reset clears fill levels and control; table contents need no reset.
module signature_histogram_jaccard #(
  parameter int MAX_SIGNATURES    = 64,
  parameter int COUNT_BITS        = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [5:0]  in_bond_type,
  input  logic [3:0]  in_neighbor_count,
  input  logic [6:0]  in_common_bonds,
  input  logic [3:0]  in_chain_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [5:0]  out_entry_index,
  output logic [15:0] out_entry_count,
  output logic [21:0] out_intersection_sum,
  output logic [22:0] out_union_sum,
  output logic [16:0] out_jaccard_q16
);
  localparam int AW = (MAX_SIGNATURES > 1) ? $clog2(MAX_SIGNATURES) : 1;
  localparam int FW = AW + 1;
  localparam int SW = COUNT_BITS + AW + 1;
  localparam int NW = SW + 16;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
  localparam logic [FW-1:0] FMAX = FW'(MAX_SIGNATURES);
  localparam int DVW = $clog2(NW + 1);
  localparam logic [3:0] S_IDLE = 4'd0, S_ARD = 4'd1, S_ACHK = 4'd2, S_AWR = 4'd3,
    S_OUT = 4'd4, S_CRDA = 4'd5, S_CRDB = 4'd6, S_CCHK = 4'd7, S_CACC = 4'd8,
    S_DIV = 4'd9, S_CRDS = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [FW-1:0] fill_a_r, fill_b_r;
  shj_pkg::sig_t sig_a_mem [MAX_SIGNATURES];
  shj_pkg::sig_t sig_b_mem [MAX_SIGNATURES];
  logic [COUNT_BITS-1:0] cnt_a_mem [MAX_SIGNATURES];
  logic [COUNT_BITS-1:0] cnt_b_mem [MAX_SIGNATURES];
  shj_pkg::sig_t rsig_a_r, rsig_b_r;
  logic [COUNT_BITS-1:0] rcnt_a_r, rcnt_b_r;

  logic [1:0] op_r;
  shj_pkg::sig_t key_r;
  logic [FW-1:0] i_r, j_r;
  logic pass_r, found_r;
  logic [COUNT_BITS-1:0] ca_r, cb_r;
  logic [SW-1:0] inter_r, uni_r;
  logic [NW-1:0] rem_r, quo_r;
  logic [DVW-1:0] dcnt_r;

  logic rd_en, wr_a, wr_b;
  logic [AW-1:0] rd_addr, wr_addr;
  shj_pkg::sig_t wr_sig;
  logic [COUNT_BITS-1:0] wr_cnt;

  logic [1:0] o_status_r;
  logic [5:0] o_idx_r;
  logic [15:0] o_cnt_r;
  logic [21:0] o_int_r;
  logic [22:0] o_uni_r;
  logic [16:0] o_jac_r;
  logic out_valid_r;

  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_status = o_status_r;
  assign out_entry_index = o_idx_r;
  assign out_entry_count = o_cnt_r;
  assign out_intersection_sum = o_int_r;
  assign out_union_sum = o_uni_r;
  assign out_jaccard_q16 = o_jac_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rsig_a_r <= sig_a_mem[rd_addr];
      rcnt_a_r <= cnt_a_mem[rd_addr];
      rsig_b_r <= sig_b_mem[rd_addr];
      rcnt_b_r <= cnt_b_mem[rd_addr];
    end
    if (wr_a) begin
      sig_a_mem[wr_addr] <= wr_sig;
      cnt_a_mem[wr_addr] <= wr_cnt;
    end
    if (wr_b) begin
      sig_b_mem[wr_addr] <= wr_sig;
      cnt_b_mem[wr_addr] <= wr_cnt;
    end
  end

  logic [FW-1:0] afill;
  logic hit_a, hit_b, hit;
  logic [COUNT_BITS-1:0] rcnt, inc;
  logic [NW-1:0] rem_sh, uni_ext;
  assign afill = (op_r == shj_pkg::OP_ADD_A) ? fill_a_r : fill_b_r;
  assign hit_a = (rsig_a_r == key_r);
  assign hit_b = (rsig_b_r == key_r);
  assign hit = (op_r == shj_pkg::OP_ADD_A) ? hit_a : hit_b;
  assign rcnt = (op_r == shj_pkg::OP_ADD_A) ? rcnt_a_r : rcnt_b_r;
  assign inc = (rcnt == CMAX) ? rcnt : rcnt + 1'b1;
  assign rem_sh = {rem_r[NW-2:0], quo_r[NW-1]};
  assign uni_ext = NW'(uni_r);

  always_comb begin
    state_nxt = state_r;
    rd_en = 1'b0;
    rd_addr = i_r[AW-1:0];
    wr_a = 1'b0;
    wr_b = 1'b0;
    wr_addr = i_r[AW-1:0];
    wr_sig = key_r;
    wr_cnt = inc;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          priority case (in_opcode)
            shj_pkg::OP_CLEAR: state_nxt = S_OUT;
            shj_pkg::OP_CMP: state_nxt = S_CRDA;
            default: state_nxt = S_ARD;
          endcase
        end
      end
      S_ARD: begin
        if (i_r >= afill) begin
          state_nxt = S_AWR;
        end else begin
          rd_en = 1'b1;
          state_nxt = S_ACHK;
        end
      end
      S_ACHK: state_nxt = hit ? S_AWR : S_ARD;
      S_AWR: begin
        if (found_r) begin
          wr_a = (op_r == shj_pkg::OP_ADD_A);
          wr_b = (op_r == shj_pkg::OP_ADD_B);
          wr_cnt = ca_r;
        end else if (afill < FMAX) begin
          wr_a = (op_r == shj_pkg::OP_ADD_A);
          wr_b = (op_r == shj_pkg::OP_ADD_B);
          wr_addr = afill[AW-1:0];
          wr_cnt = COUNT_BITS'(1);
        end
        state_nxt = S_OUT;
      end
      S_CRDA: begin
        if (i_r >= (pass_r ? fill_b_r : fill_a_r)) begin
          state_nxt = pass_r ? S_DIV : S_CRDA;
        end else begin
          rd_en = 1'b1;
          state_nxt = S_CRDS;
        end
      end
      S_CRDS: state_nxt = S_CRDB;
      S_CRDB: begin
        if (j_r >= (pass_r ? fill_a_r : fill_b_r)) begin
          state_nxt = S_CACC;
        end else begin
          rd_en = 1'b1;
          rd_addr = j_r[AW-1:0];
          state_nxt = S_CCHK;
        end
      end
      S_CCHK: state_nxt = (pass_r ? hit_a : hit_b) ? S_CACC : S_CRDB;
      S_CACC: state_nxt = S_CRDA;
      S_DIV: state_nxt = (dcnt_r == DVW'(NW)) ? S_OUT : S_DIV;
      S_OUT: state_nxt = out_stall ? S_OUT : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_a_r <= '0;
      fill_b_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op_r <= in_opcode;
            key_r <= {in_bond_type, in_neighbor_count, in_common_bonds, in_chain_length};
            i_r <= '0;
            j_r <= '0;
            pass_r <= 1'b0;
            found_r <= 1'b0;
            inter_r <= '0;
            uni_r <= '0;
            o_status_r <= shj_pkg::ST_NEW;
            o_idx_r <= '0;
            o_cnt_r <= '0;
            o_int_r <= '0;
            o_uni_r <= '0;
            o_jac_r <= '0;
            if (in_opcode == shj_pkg::OP_CLEAR) begin
              fill_a_r <= '0;
              fill_b_r <= '0;
              out_valid_r <= 1'b1;
            end
          end
        end
        S_ARD: ;
        S_ACHK: begin
          if (hit) begin
            found_r <= 1'b1;
            ca_r <= inc;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        S_AWR: begin
          out_valid_r <= 1'b1;
          if (found_r) begin
            o_status_r <= shj_pkg::ST_OLD;
            o_idx_r <= 6'(i_r);
            o_cnt_r <= 16'(ca_r);
          end else if (afill < FMAX) begin
            o_idx_r <= 6'(afill);
            o_cnt_r <= 16'd1;
            if (op_r == shj_pkg::OP_ADD_A) fill_a_r <= fill_a_r + 1'b1;
            else fill_b_r <= fill_b_r + 1'b1;
          end else begin
            o_status_r <= shj_pkg::ST_FULL;
          end
        end
        S_CRDA: begin
          if (i_r >= (pass_r ? fill_b_r : fill_a_r)) begin
            if (!pass_r) begin
              pass_r <= 1'b1;
              i_r <= '0;
            end else begin
              rem_r <= '0;
              quo_r <= {inter_r, 16'd0};
              dcnt_r <= '0;
            end
          end
          j_r <= '0;
          found_r <= 1'b0;
        end
        S_CRDS: begin
          key_r <= pass_r ? rsig_b_r : rsig_a_r;
          ca_r <= pass_r ? rcnt_b_r : rcnt_a_r;
        end
        S_CRDB: ;
        S_CCHK: begin
          if (pass_r ? hit_a : hit_b) begin
            found_r <= 1'b1;
            cb_r <= rcnt_b_r;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_CACC: begin
          i_r <= i_r + 1'b1;
          if (!pass_r) begin
            if (found_r) begin
              inter_r <= inter_r + SW'((ca_r < cb_r) ? ca_r : cb_r);
              uni_r <= uni_r + SW'((ca_r > cb_r) ? ca_r : cb_r);
            end else begin
              uni_r <= uni_r + SW'(ca_r);
            end
          end else if (!found_r) begin
            uni_r <= uni_r + SW'(ca_r);
          end
        end
        S_DIV: begin
          if (dcnt_r == DVW'(NW)) begin
            out_valid_r <= 1'b1;
            if (uni_r == '0) begin
              o_status_r <= shj_pkg::ST_EMPTY;
            end else begin
              o_int_r <= 22'(inter_r);
              o_uni_r <= 23'(uni_r);
              o_jac_r <= 17'(quo_r);
            end
          end else begin
            dcnt_r <= dcnt_r + 1'b1;
            if (rem_sh >= uni_ext) begin
              rem_r <= rem_sh - uni_ext;
              quo_r <= {quo_r[NW-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              quo_r <= {quo_r[NW-2:0], 1'b0};
            end
          end
        end
        S_OUT: ;
        default: ;
      endcase
    end
  end

  a_fill_a_max: assert property (@(posedge clk) disable iff (!rst_n) fill_a_r <= FMAX)
    else $error("fill_a beyond capacity");
  a_fill_b_max: assert property (@(posedge clk) disable iff (!rst_n) fill_b_r <= FMAX)
    else $error("fill_b beyond capacity");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("word accepted while busy");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n) !(wr_a && wr_b))
    else $error("both tables written");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(o_status_r)))
    else $error("result dropped");
endmodule

/* sim/signature_histogram_jaccard_test.sv */
// Testbench for signature_histogram_jaccard: drives add, clear and compare words and
// checks every result word against a histogram predictor. Depends on shj_pkg.
`timescale 1ns / 1ps

module signature_histogram_jaccard_test;
  localparam int TABLE_DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] bond_type;
    logic [3:0] neighbor_count;
    logic [6:0] common_bonds;
    logic [3:0] chain_length;
  } bond_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  entry_index;
    logic [15:0] entry_count;
    logic [21:0] intersection_sum;
    logic [22:0] union_sum;
    logic [16:0] jaccard_q16;
  } histo_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = shj_pkg::OP_CLEAR;
  logic [5:0] in_bond_type = '0;
  logic [3:0] in_neighbor_count = '0;
  logic [6:0] in_common_bonds = '0;
  logic [3:0] in_chain_length = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [5:0] out_entry_index;
  logic [15:0] out_entry_count;
  logic [21:0] out_intersection_sum;
  logic [22:0] out_union_sum;
  logic [16:0] out_jaccard_q16;

  signature_histogram_jaccard dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_bond_type(in_bond_type),
    .in_neighbor_count(in_neighbor_count), .in_common_bonds(in_common_bonds),
    .in_chain_length(in_chain_length),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_entry_index(out_entry_index),
    .out_entry_count(out_entry_count), .out_intersection_sum(out_intersection_sum),
    .out_union_sum(out_union_sum), .out_jaccard_q16(out_jaccard_q16)
  );

  always #10 clk = ~clk;

  bond_word_t pending_words[$];
  histo_result_t expected_results[$];
  bond_word_t driven_word;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  shj_pkg::sig_t sigs_a[TABLE_DEPTH];
  shj_pkg::sig_t sigs_b[TABLE_DEPTH];
  logic [15:0] counts_a[TABLE_DEPTH];
  logic [15:0] counts_b[TABLE_DEPTH];
  int fill_a = 0;
  int fill_b = 0;
  shj_pkg::sig_t sig_pool[8];

  function automatic int find_sig(ref shj_pkg::sig_t sigs[TABLE_DEPTH], input int fill,
      input shj_pkg::sig_t s);
    for (int i = 0; i < fill; i++) begin
      if (sigs[i] == s) return i;
    end
    return -1;
  endfunction

  function automatic histo_result_t add_signature(ref shj_pkg::sig_t sigs[TABLE_DEPTH],
      ref logic [15:0] counts[TABLE_DEPTH], ref int fill, input shj_pkg::sig_t s);
    histo_result_t r;
    int pos;
    r = '0;
    pos = find_sig(sigs, fill, s);
    if (pos >= 0) begin
      if (counts[pos] != 16'hFFFF) counts[pos] = counts[pos] + 16'd1;
      r.status = shj_pkg::ST_OLD;
      r.entry_index = pos[5:0];
      r.entry_count = counts[pos];
    end else if (fill >= TABLE_DEPTH) begin
      r.status = shj_pkg::ST_FULL;
    end else begin
      sigs[fill] = s;
      counts[fill] = 16'd1;
      r.status = shj_pkg::ST_NEW;
      r.entry_index = fill[5:0];
      r.entry_count = 16'd1;
      fill++;
    end
    return r;
  endfunction

  function automatic histo_result_t compare_histograms();
    histo_result_t r;
    longint inter;
    longint uni;
    int pb;
    longint ca;
    longint cb;
    longint q;
    r = '0;
    inter = 0;
    uni = 0;
    for (int i = 0; i < fill_a; i++) begin
      ca = counts_a[i];
      pb = find_sig(sigs_b, fill_b, sigs_a[i]);
      if (pb >= 0) begin
        cb = counts_b[pb];
        inter += (ca < cb) ? ca : cb;
        uni += (ca > cb) ? ca : cb;
      end else begin
        uni += ca;
      end
    end
    for (int i = 0; i < fill_b; i++) begin
      if (find_sig(sigs_a, fill_a, sigs_b[i]) < 0) uni += counts_b[i];
    end
    if (uni == 0) begin
      r.status = shj_pkg::ST_EMPTY;
    end else begin
      r.status = shj_pkg::ST_NEW;
      r.intersection_sum = inter[21:0];
      r.union_sum = uni[22:0];
      q = (inter << 16) / uni;
      r.jaccard_q16 = q[16:0];
    end
    return r;
  endfunction

  function automatic histo_result_t predict_word(bond_word_t w);
    histo_result_t r;
    shj_pkg::sig_t s;
    r = '0;
    s = {w.bond_type, w.neighbor_count, w.common_bonds, w.chain_length};
    case (w.opcode)
      shj_pkg::OP_CLEAR: begin
        fill_a = 0;
        fill_b = 0;
      end
      shj_pkg::OP_ADD_A: r = add_signature(sigs_a, counts_a, fill_a, s);
      shj_pkg::OP_ADD_B: r = add_signature(sigs_b, counts_b, fill_b, s);
      default: r = compare_histograms();
    endcase
    return r;
  endfunction

  task automatic push_word(logic [1:0] op, shj_pkg::sig_t s);
    bond_word_t w;
    w.opcode = op;
    {w.bond_type, w.neighbor_count, w.common_bonds, w.chain_length} = s;
    pending_words = {pending_words, w};
  endtask

  function automatic shj_pkg::sig_t random_sig();
    if ($urandom_range(2) == 0) return shj_pkg::sig_t'($urandom);
    return sig_pool[$urandom_range(7)];
  endfunction

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic random_episodes(int n_words);
    int left;
    int nadds;
    left = n_words;
    while (left > 0) begin
      for (int i = 0; i < 8; i++) sig_pool[i] = shj_pkg::sig_t'($urandom);
      push_word(shj_pkg::OP_CLEAR, shj_pkg::sig_t'($urandom));
      left--;
      if ($urandom_range(19) == 0) begin
        for (int i = 0; i < TABLE_DEPTH + 3; i++)
          push_word(shj_pkg::OP_ADD_A, shj_pkg::sig_t'($urandom));
        for (int i = 0; i < 4; i++) push_word(shj_pkg::OP_ADD_B, random_sig());
        push_word(shj_pkg::OP_ADD_A, sig_pool[0]);
        push_word(shj_pkg::OP_CMP, shj_pkg::sig_t'($urandom));
        left -= TABLE_DEPTH + 9;
      end else begin
        nadds = $urandom_range(14, 1);
        for (int i = 0; i < nadds; i++) begin
          case ($urandom_range(9))
            0: push_word(shj_pkg::OP_CMP, shj_pkg::sig_t'($urandom));
            1: push_word(shj_pkg::OP_CLEAR, shj_pkg::sig_t'($urandom));
            2, 3, 4, 5: push_word(shj_pkg::OP_ADD_A, random_sig());
            default: push_word(shj_pkg::OP_ADD_B, random_sig());
          endcase
        end
        push_word(shj_pkg::OP_CMP, shj_pkg::sig_t'($urandom));
        left -= nadds + 1;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_results = {expected_results, predict_word(driven_word)};
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          driven_word = pending_words.pop_front();
          in_opcode <= driven_word.opcode;
          in_bond_type <= driven_word.bond_type;
          in_neighbor_count <= driven_word.neighbor_count;
          in_common_bonds <= driven_word.common_bonds;
          in_chain_length <= driven_word.chain_length;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    histo_result_t got;
    histo_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_status, out_entry_index, out_entry_count,
               out_intersection_sum, out_union_sum, out_jaccard_q16};
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: status %0d/%0d index %0d/%0d count %0d/%0d ",
                       want.status, got.status, want.entry_index, got.entry_index,
                       want.entry_count, got.entry_count,
                       "inter %0d/%0d union %0d/%0d jac %0d/%0d (exp/act)",
                       want.intersection_sum, got.intersection_sum,
                       want.union_sum, got.union_sum,
                       want.jaccard_q16, got.jaccard_q16);
          end
        end
      end
      if (!hold_done && results_seen == 150) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    shj_pkg::sig_t s;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 24;
    recv_idle_pct = 67;
    push_word(shj_pkg::OP_CMP, '0);
    push_word(shj_pkg::OP_ADD_A, '0);
    push_word(shj_pkg::OP_ADD_A, '1);
    push_word(shj_pkg::OP_ADD_A, '1);
    push_word(shj_pkg::OP_CMP, '1);
    push_word(shj_pkg::OP_ADD_B, '1);
    push_word(shj_pkg::OP_ADD_B, '0);
    push_word(shj_pkg::OP_ADD_B, '1);
    push_word(shj_pkg::OP_ADD_A, '0);
    push_word(shj_pkg::OP_CMP, '0);
    push_word(shj_pkg::OP_ADD_B, 21'h0ABCDE);
    push_word(shj_pkg::OP_CMP, '0);
    push_word(shj_pkg::OP_CLEAR, '1);
    push_word(shj_pkg::OP_CMP, '1);
    push_word(shj_pkg::OP_ADD_B, 21'h155555);
    push_word(shj_pkg::OP_CMP, '0);
    push_word(shj_pkg::OP_CLEAR, '0);
    random_episodes(500);
    wait_drained();

    send_idle_pct = 67;
    recv_idle_pct = 24;
    random_episodes(300);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_episodes(200);
    s = shj_pkg::sig_t'($urandom);
    push_word(shj_pkg::OP_CLEAR, '0);
    for (int i = 0; i < 40; i++) push_word(shj_pkg::OP_ADD_A, s);
    push_word(shj_pkg::OP_ADD_B, s);
    push_word(shj_pkg::OP_CMP, '0);
    wait_drained();
    repeat (50) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
